### design/gtca_pkg.sv
`default_nettype none
package gtca_pkg;

  localparam int GlucoseW = 16;
  localparam int ThreshW  = 15;
  localparam int VibeW    = 3;
  localparam int SecW     = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALARMS_EN  = 3'd0,
    REG_HIGH_THR   = 3'd1,
    REG_LOW_THR    = 3'd2,
    REG_HIGH_VIBE  = 3'd3,
    REG_LOW_VIBE   = 3'd4,
    REG_HIGH_SEC   = 3'd5,
    REG_LOW_SEC    = 3'd6
  } cfg_reg_e;

  localparam logic REQ_TICK = 1'b1;

  localparam logic [VibeW-1:0] VIBE_NONE = 3'd0;
  localparam logic [VibeW-1:0] VIBE_MIN  = 3'd1;
  localparam logic [VibeW-1:0] VIBE_MAX  = 3'd4;

  localparam logic                RST_ALARMS_EN = 1'b0;
  localparam logic [ThreshW-1:0]  RST_HIGH_THR  = 15'd180;
  localparam logic [ThreshW-1:0]  RST_LOW_THR   = 15'd70;
  localparam logic [VibeW-1:0]    RST_HIGH_VIBE = 3'd1;
  localparam logic [VibeW-1:0]    RST_LOW_VIBE  = 3'd1;
  localparam logic [SecW-1:0]     RST_HIGH_SEC  = 8'd5;
  localparam logic [SecW-1:0]     RST_LOW_SEC   = 8'd5;
  localparam logic [GlucoseW-1:0] PREV_RESET    = 16'hFFFF;

  typedef struct packed {
    logic                alarms_en;
    logic [ThreshW-1:0]  high_thr;
    logic [ThreshW-1:0]  low_thr;
    logic [VibeW-1:0]    high_vibe;
    logic [VibeW-1:0]    low_vibe;
    logic [SecW-1:0]     high_sec;
    logic [SecW-1:0]     low_sec;
  } cfg_t;

  typedef struct packed {
    logic wr;
    logic halt;
  } cfg_evt_t;

  typedef struct packed {
    logic             play;
    logic [VibeW-1:0] play_type;
    logic             cancel;
    logic [SecW-1:0]  seconds_left;
    logic [VibeW-1:0] active_type;
  } result_t;

endpackage
`default_nettype wire

### design/glucose_threshold_crossing_alarm_unit.sv
`default_nettype none
// A word enters the input register; its result then goes to the result register.
// Throughput: one word per cycle when not stalled; the two registers part the sides.
// A stalled result holds the pipeline; the input register still takes one word.
// Reset clears the valid flags, the alarm countdown and the stored reading (to minus one)
// and loads the configuration defaults.
module glucose_threshold_crossing_alarm_unit
  import gtca_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                req_type_i,
  input  wire logic [GlucoseW-1:0] glucose_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     play_o,
  output logic [VibeW-1:0]         play_type_o,
  output logic                     cancel_o,
  output logic [SecW-1:0]          seconds_left_o,
  output logic [VibeW-1:0]         active_type_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic                in_valid_q;
  logic                req_q;
  logic [GlucoseW-1:0] glucose_q;
  logic                out_valid_q;
  result_t             res_q;
  result_t             res;
  cfg_t                cfg;
  cfg_evt_t            evt;
  logic                advance, fire, in_load;

  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = in_valid_q && advance;
  assign in_load = !in_valid_q || advance;

  gtca_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg),
    .evt_o (evt)
  );

  gtca_core u_core (
    .clk_i,
    .rst_ni,
    .fire_i     (fire),
    .req_type_i (req_q),
    .glucose_i  (glucose_q),
    .cfg_i      (cfg),
    .evt_i      (evt),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      req_q     <= req_type_i;
      glucose_q <= glucose_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign in_stall_o     = !in_load;
  assign out_valid_o    = out_valid_q;
  assign play_o         = res_q.play;
  assign play_type_o    = res_q.play_type;
  assign cancel_o       = res_q.cancel;
  assign seconds_left_o = res_q.seconds_left;
  assign active_type_o  = res_q.active_type;

endmodule
`default_nettype wire

### design/gtca_cfg_regs.sv
`default_nettype none
module gtca_cfg_regs
  import gtca_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o,
  output cfg_evt_t                 evt_o
);

  cfg_t cfg_q, cfg_d;
  logic hit;

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      hit = 1'b1;
      case (cfg_reg_e'(cfg_index_i))
        REG_ALARMS_EN: cfg_d.alarms_en = cfg_data_i[0];
        REG_HIGH_THR:  cfg_d.high_thr  = cfg_data_i[ThreshW-1:0];
        REG_LOW_THR:   cfg_d.low_thr   = cfg_data_i[ThreshW-1:0];
        REG_HIGH_VIBE: cfg_d.high_vibe = cfg_data_i[VibeW-1:0];
        REG_LOW_VIBE:  cfg_d.low_vibe  = cfg_data_i[VibeW-1:0];
        REG_HIGH_SEC:  cfg_d.high_sec  = cfg_data_i[SecW-1:0];
        REG_LOW_SEC:   cfg_d.low_sec   = cfg_data_i[SecW-1:0];
        default:       hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarms_en <= RST_ALARMS_EN;
      cfg_q.high_thr  <= RST_HIGH_THR;
      cfg_q.low_thr   <= RST_LOW_THR;
      cfg_q.high_vibe <= RST_HIGH_VIBE;
      cfg_q.low_vibe  <= RST_LOW_VIBE;
      cfg_q.high_sec  <= RST_HIGH_SEC;
      cfg_q.low_sec   <= RST_LOW_SEC;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o      = cfg_q;
  assign evt_o.wr   = hit;
  assign evt_o.halt = hit && !cfg_d.alarms_en;

endmodule
`default_nettype wire

### design/gtca_core.sv
`default_nettype none
module gtca_core
  import gtca_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire logic                req_type_i,
  input  wire logic [GlucoseW-1:0] glucose_i,
  input  wire cfg_t                cfg_i,
  input  wire cfg_evt_t            evt_i,
  output result_t                  res_o
);

  logic [GlucoseW-1:0] prev_q, prev_d;
  logic [SecW-1:0]     plays_q, plays_d;
  logic [VibeW-1:0]    run_q, run_d;

  logic signed [GlucoseW-1:0] bg, prev, hi, lo;
  logic                       prev_high, prev_low, start_high, start_low;
  logic [VibeW-1:0]           st_type;
  logic [SecW-1:0]            st_count;
  logic [SecW-1:0]            dec;
  logic                       tick_play;

  assign bg   = signed'(glucose_i);
  assign prev = signed'(prev_q);
  assign hi   = signed'({1'b0, cfg_i.high_thr});
  assign lo   = signed'({1'b0, cfg_i.low_thr});

  assign prev_high  = prev > hi;
  assign prev_low   = prev < lo;
  assign start_high = (bg > 0) && (prev > 0) && !prev_high && (bg > hi);
  assign start_low  = (bg > 0) && (prev > 0) && !start_high && !prev_low && (bg < lo);
  assign st_type    = start_high ? cfg_i.high_vibe : cfg_i.low_vibe;
  assign st_count   = start_high ? cfg_i.high_sec : cfg_i.low_sec;
  assign dec        = plays_q - SecW'(1);
  assign tick_play  = (run_q >= VIBE_MIN) && (run_q <= VIBE_MAX);

  always_comb begin
    prev_d    = prev_q;
    plays_d   = plays_q;
    run_d     = run_q;
    res_o     = '0;
    if (req_type_i == REQ_TICK) begin
      if (plays_q != '0) begin
        res_o.play      = tick_play;
        res_o.play_type = tick_play ? run_q : VIBE_NONE;
        plays_d         = dec;
        if (dec == '0) begin
          run_d = VIBE_NONE;
        end
      end
    end else begin
      prev_d = glucose_i;
      if (!cfg_i.alarms_en) begin
        plays_d      = '0;
        run_d        = VIBE_NONE;
        res_o.cancel = 1'b1;
      end else if (start_high || start_low) begin
        res_o.cancel = 1'b1;
        if (st_type == VIBE_NONE || st_count == '0) begin
          plays_d = '0;
          run_d   = VIBE_NONE;
        end else begin
          res_o.play      = (st_type >= VIBE_MIN) && (st_type <= VIBE_MAX);
          res_o.play_type = res_o.play ? st_type : VIBE_NONE;
          plays_d         = st_count - SecW'(1);
          run_d           = (plays_d == '0) ? VIBE_NONE : st_type;
        end
      end
    end
    res_o.seconds_left = plays_d;
    res_o.active_type  = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= PREV_RESET;
      plays_q <= '0;
      run_q   <= VIBE_NONE;
    end else if (evt_i.wr) begin
      prev_q <= PREV_RESET;
      if (evt_i.halt) begin
        plays_q <= '0;
        run_q   <= VIBE_NONE;
      end
    end else if (fire_i) begin
      prev_q  <= prev_d;
      plays_q <= plays_d;
      run_q   <= run_d;
    end
  end

endmodule
`default_nettype wire
